>>> rtl/dtns_pkg.sv
// Shared types and constants for the duration text parser.
package dtns_pkg;

   localparam int unsigned COUNT_W  = 64;
   localparam int unsigned FACTOR_W = 47;
   localparam int unsigned NS_W     = 63;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_DIGIT_OVF = 3'd2,
      STATUS_ZERO      = 3'd3,
      STATUS_BAD_UNIT  = 3'd4,
      STATUS_NS_OVF    = 3'd5
   } status_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_DIG_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIG_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_N     = 8'h6e;
   localparam logic [CHAR_W-1:0] CHAR_U     = 8'h75;
   localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6d;
   localparam logic [CHAR_W-1:0] CHAR_S     = 8'h73;
   localparam logic [CHAR_W-1:0] CHAR_H     = 8'h68;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;

   localparam logic [COUNT_W-1:0] SIGNED_MAX  = 64'd9223372036854775807;
   localparam logic [COUNT_W-1:0] NS_PER_NS   = 64'd1;
   localparam logic [COUNT_W-1:0] NS_PER_US   = 64'd1000;
   localparam logic [COUNT_W-1:0] NS_PER_MS   = 64'd1000000;
   localparam logic [COUNT_W-1:0] NS_PER_S    = 64'd1000000000;
   localparam logic [COUNT_W-1:0] NS_PER_MIN  = 64'd60000000000;
   localparam logic [COUNT_W-1:0] NS_PER_HOUR = 64'd3600000000000;
   localparam logic [COUNT_W-1:0] NS_PER_DAY  = 64'd86400000000000;

   localparam logic [COUNT_W-1:0] LIMIT_NS   = SIGNED_MAX / NS_PER_NS;
   localparam logic [COUNT_W-1:0] LIMIT_US   = SIGNED_MAX / NS_PER_US;
   localparam logic [COUNT_W-1:0] LIMIT_MS   = SIGNED_MAX / NS_PER_MS;
   localparam logic [COUNT_W-1:0] LIMIT_S    = SIGNED_MAX / NS_PER_S;
   localparam logic [COUNT_W-1:0] LIMIT_MIN  = SIGNED_MAX / NS_PER_MIN;
   localparam logic [COUNT_W-1:0] LIMIT_HOUR = SIGNED_MAX / NS_PER_HOUR;
   localparam logic [COUNT_W-1:0] LIMIT_DAY  = SIGNED_MAX / NS_PER_DAY;

   typedef struct packed {
      logic                valid;
      logic [COUNT_W-1:0]  count;
      logic [FACTOR_W-1:0] factor;
      status_type          status;
   } term_type;

endpackage

>>> rtl/dtns_req_if.sv
// Text byte channel interface.
interface dtns_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

>>> rtl/dtns_rsp_if.sv
// Duration result channel interface.
interface dtns_rsp_if;
   logic        valid;
   logic        ready;
   logic [62:0] elapsed_ns;
   logic [2:0]  status;

   modport source (output valid, output elapsed_ns, output status, input ready);
   modport sink (input valid, input elapsed_ns, input status, output ready);
endinterface

>>> rtl/dtns_parser.sv
// Input register, digit accumulator and unit decoder.
module dtns_parser (
   input  logic               clock,
   input  logic               reset,
   dtns_req_if.sink           req,
   output dtns_pkg::term_type term,
   input  logic               term_ready
);

   logic                           in_valid_ff, in_valid_in;
   logic [dtns_pkg::CHAR_W-1:0]    char_ff, char_in;

   logic                           at_start_ff, at_start_in;
   logic                           in_unit_ff, in_unit_in;
   logic [dtns_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic                           ovf_ff, ovf_in;
   logic [dtns_pkg::CHAR_W-1:0]    unit_c0_ff, unit_c0_in;
   logic [dtns_pkg::CHAR_W-1:0]    unit_c1_ff, unit_c1_in;
   logic [1:0]                     unit_len_ff, unit_len_in;

   logic                           is_nul;
   logic                           is_digit;
   logic                           take;
   logic [dtns_pkg::COUNT_W+3:0]   next_total;
   logic [dtns_pkg::FACTOR_W-1:0]  factor;
   logic [dtns_pkg::COUNT_W-1:0]   limit;
   dtns_pkg::status_type           status;

   assign is_nul   = (char_ff == dtns_pkg::CHAR_NUL);
   assign is_digit = !in_unit_ff && (char_ff >= dtns_pkg::CHAR_DIG_0)
                     && (char_ff <= dtns_pkg::CHAR_DIG_9);
   assign take     = in_valid_ff && (!is_nul || term_ready);
   assign req.ready = !in_valid_ff || take;

   assign next_total = ({4'b0, total_ff} << 3) + ({4'b0, total_ff} << 1)
                       + {64'b0, char_ff[3:0]};

   always_comb begin
      factor = '0;
      limit  = '0;
      if (unit_len_ff == 2'd1) begin
         unique case (unit_c0_ff)
            dtns_pkg::CHAR_S: begin
               factor = dtns_pkg::NS_PER_S[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_S;
            end
            dtns_pkg::CHAR_M: begin
               factor = dtns_pkg::NS_PER_MIN[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_MIN;
            end
            dtns_pkg::CHAR_H: begin
               factor = dtns_pkg::NS_PER_HOUR[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_HOUR;
            end
            dtns_pkg::CHAR_D: begin
               factor = dtns_pkg::NS_PER_DAY[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_DAY;
            end
            default: begin
               factor = '0;
               limit  = '0;
            end
         endcase
      end else if (unit_len_ff == 2'd2 && unit_c1_ff == dtns_pkg::CHAR_S) begin
         unique case (unit_c0_ff)
            dtns_pkg::CHAR_N: begin
               factor = dtns_pkg::NS_PER_NS[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_NS;
            end
            dtns_pkg::CHAR_U: begin
               factor = dtns_pkg::NS_PER_US[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_US;
            end
            dtns_pkg::CHAR_M: begin
               factor = dtns_pkg::NS_PER_MS[dtns_pkg::FACTOR_W-1:0];
               limit  = dtns_pkg::LIMIT_MS;
            end
            default: begin
               factor = '0;
               limit  = '0;
            end
         endcase
      end
   end

   always_comb begin
      if (at_start_ff) begin
         status = dtns_pkg::STATUS_EMPTY;
      end else if (ovf_ff) begin
         status = dtns_pkg::STATUS_DIGIT_OVF;
      end else if (total_ff == '0) begin
         status = dtns_pkg::STATUS_ZERO;
      end else if (factor == '0) begin
         status = dtns_pkg::STATUS_BAD_UNIT;
      end else if (total_ff > limit) begin
         status = dtns_pkg::STATUS_NS_OVF;
      end else begin
         status = dtns_pkg::STATUS_OK;
      end
   end

   assign term.valid  = in_valid_ff && is_nul;
   assign term.count  = total_ff;
   assign term.factor = (status == dtns_pkg::STATUS_OK) ? factor : '0;
   assign term.status = status;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         char_in     = req.char_code;
      end
   end

   always_comb begin
      at_start_in = at_start_ff;
      in_unit_in  = in_unit_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      unit_c0_in  = unit_c0_ff;
      unit_c1_in  = unit_c1_ff;
      unit_len_in = unit_len_ff;
      if (take) begin
         if (is_nul) begin
            at_start_in = 1'b1;
            in_unit_in  = 1'b0;
            total_in    = '0;
            ovf_in      = 1'b0;
            unit_c0_in  = '0;
            unit_c1_in  = '0;
            unit_len_in = '0;
         end else begin
            at_start_in = 1'b0;
            if (is_digit) begin
               if (!ovf_ff) begin
                  if (next_total[dtns_pkg::COUNT_W+3:dtns_pkg::COUNT_W] != 4'd0) begin
                     ovf_in = 1'b1;
                  end else begin
                     total_in = next_total[dtns_pkg::COUNT_W-1:0];
                  end
               end
            end else begin
               in_unit_in = 1'b1;
               if (unit_len_ff == 2'd0) begin
                  unit_c0_in = char_ff;
               end else if (unit_len_ff == 2'd1) begin
                  unit_c1_in = char_ff;
               end
               if (unit_len_ff != 2'd3) begin
                  unit_len_in = unit_len_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         at_start_ff <= 1'b1;
         in_unit_ff  <= 1'b0;
         total_ff    <= '0;
         ovf_ff      <= 1'b0;
         unit_c0_ff  <= '0;
         unit_c1_ff  <= '0;
         unit_len_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         at_start_ff <= at_start_in;
         in_unit_ff  <= in_unit_in;
         total_ff    <= total_in;
         ovf_ff      <= ovf_in;
         unit_c0_ff  <= unit_c0_in;
         unit_c1_ff  <= unit_c1_in;
         unit_len_ff <= unit_len_in;
      end
   end

`ifndef SYNTHESIS
   a_term_clears_state: assert property (@(posedge clock) disable iff (reset)
      (take && is_nul) |=> (at_start_ff && total_ff == '0 && unit_len_ff == 2'd0))
      else $error("parse state not cleared after terminator");

   a_unit_has_length: assert property (@(posedge clock) disable iff (reset)
      in_unit_ff |-> (unit_len_ff != 2'd0))
      else $error("unit part flagged with no unit bytes");

   a_start_is_blank: assert property (@(posedge clock) disable iff (reset)
      at_start_ff |-> (!in_unit_ff && !ovf_ff && total_ff == '0))
      else $error("state not blank at text start");
`endif

endmodule

>>> rtl/dtns_scaler.sv
// Pipelined constant-factor multiply and result register.
module dtns_scaler (
   input  logic               clock,
   input  logic               reset,
   input  dtns_pkg::term_type term,
   output logic               term_ready,
   dtns_rsp_if.source         rsp
);

   logic                            s1_valid_ff, s1_valid_in;
   logic [dtns_pkg::COUNT_W-1:0]    s1_count_ff, s1_count_in;
   logic [dtns_pkg::FACTOR_W-1:0]   s1_factor_ff, s1_factor_in;
   dtns_pkg::status_type            s1_status_ff, s1_status_in;

   logic                            s2_valid_ff, s2_valid_in;
   logic [63:0]                     s2_p_ll_ff, s2_p_ll_in;
   logic [31:0]                     s2_p_hl_ff, s2_p_hl_in;
   logic [31:0]                     s2_p_lh_ff, s2_p_lh_in;
   dtns_pkg::status_type            s2_status_ff, s2_status_in;

   logic                            out_valid_ff, out_valid_in;
   logic [dtns_pkg::NS_W-1:0]       out_ns_ff, out_ns_in;
   dtns_pkg::status_type            out_status_ff, out_status_in;

   logic                            out_free;
   logic                            s2_free;
   logic                            s1_free;
   logic [31:0]                     prod_hl;
   logic [31:0]                     prod_lh;
   logic [31:0]                     mid_sum;
   logic [63:0]                     total_sum;

   assign out_free   = !out_valid_ff || rsp.ready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign term_ready = s1_free;

   assign prod_hl   = s1_count_ff[63:32] * s1_factor_ff[31:0];
   assign prod_lh   = s1_count_ff[31:0] * {17'b0, s1_factor_ff[46:32]};
   assign mid_sum   = s2_p_hl_ff + s2_p_lh_ff;
   assign total_sum = s2_p_ll_ff + {mid_sum, 32'b0};

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_count_in  = s1_count_ff;
      s1_factor_in = s1_factor_ff;
      s1_status_in = s1_status_ff;
      if (s1_free) begin
         s1_valid_in = term.valid;
         if (term.valid) begin
            s1_count_in  = term.count;
            s1_factor_in = term.factor;
            s1_status_in = term.status;
         end
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_p_ll_in   = s2_p_ll_ff;
      s2_p_hl_in   = s2_p_hl_ff;
      s2_p_lh_in   = s2_p_lh_ff;
      s2_status_in = s2_status_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            s2_p_ll_in   = {32'b0, s1_count_ff[31:0]} * {32'b0, s1_factor_ff[31:0]};
            s2_p_hl_in   = prod_hl;
            s2_p_lh_in   = prod_lh;
            s2_status_in = s1_status_ff;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ns_in     = out_ns_ff;
      out_status_in = out_status_ff;
      if (out_free) begin
         out_valid_in = s2_valid_ff;
         if (s2_valid_ff) begin
            out_ns_in     = total_sum[dtns_pkg::NS_W-1:0];
            out_status_in = s2_status_ff;
         end
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.elapsed_ns = out_ns_ff;
   assign rsp.status     = out_status_ff;

   always_ff @(posedge clock) begin
      s1_count_ff   <= s1_count_in;
      s1_factor_ff  <= s1_factor_in;
      s1_status_ff  <= s1_status_in;
      s2_p_ll_ff    <= s2_p_ll_in;
      s2_p_hl_ff    <= s2_p_hl_in;
      s2_p_lh_ff    <= s2_p_lh_in;
      s2_status_ff  <= s2_status_in;
      out_ns_ff     <= out_ns_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_error_zero_ns: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != dtns_pkg::STATUS_OK) |-> (out_ns_ff == '0))
      else $error("nonzero duration on error status");

   a_out_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without a pipeline item");

   a_error_zero_factor: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_status_ff != dtns_pkg::STATUS_OK) |-> (s1_factor_ff == '0))
      else $error("nonzero factor on error status");
`endif

endmodule

>>> rtl/duration_text_to_nanoseconds.sv
// Duration text parser top level.
//   channel  dir  payload                      accept
//   req      in   char_code[7:0]               req.valid && req.ready
//   rsp      out  elapsed_ns[62:0] status[2:0]  rsp.valid && rsp.ready
// One text byte is taken per cycle while no zero byte waits for the term stage;
// non-zero bytes update the parse state in the cycle after capture. A zero byte
// passes the input, term and partial-product registers to the result register.
// Reset is synchronous and clears the parse state and all valid flags.
// A stalled result holds; digit and unit bytes keep moving, and a zero byte
// waits in the input register once every stage behind it is full.
module duration_text_to_nanoseconds (
   input logic         clock,
   input logic         reset,
   dtns_req_if.sink    req,
   dtns_rsp_if.source  rsp
);

   dtns_pkg::term_type term;
   logic               term_ready;

   dtns_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .term       (term),
      .term_ready (term_ready)
   );

   dtns_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .term       (term),
      .term_ready (term_ready),
      .rsp        (rsp)
   );

endmodule

>>> test/tb_top.sv
// Testbench for the duration text parser: table-driven and random texts.
module tb_top;

   localparam int COUNT_W = dtns_pkg::COUNT_W;
   localparam int CHAR_W  = dtns_pkg::CHAR_W;
   localparam int NS_W    = dtns_pkg::NS_W;

   typedef struct packed {
      logic [NS_W-1:0]      ns;
      dtns_pkg::status_type status;
   } duration_result_type;

   typedef struct {
      string                text;
      bit                   known;
      logic [NS_W-1:0]      ns;
      dtns_pkg::status_type status;
   } text_case_type;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam int NUM_UNITS = 7;

   logic clock;
   logic reset;

   dtns_req_if req_ch ();
   dtns_rsp_if rsp_ch ();

   duration_text_to_nanoseconds uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   string unit_names [NUM_UNITS] = '{"ns", "us", "ms", "s", "m", "h", "d"};
   logic [COUNT_W-1:0] unit_limits [NUM_UNITS] =
      '{dtns_pkg::LIMIT_NS, dtns_pkg::LIMIT_US, dtns_pkg::LIMIT_MS, dtns_pkg::LIMIT_S,
        dtns_pkg::LIMIT_MIN, dtns_pkg::LIMIT_HOUR, dtns_pkg::LIMIT_DAY};

   text_case_type directed_cases [24] = '{
      '{"", 1'b1, 63'd0, dtns_pkg::STATUS_EMPTY},
      '{"1ns", 1'b1, 63'd1, dtns_pkg::STATUS_OK},
      '{"1us", 1'b1, 63'd1000, dtns_pkg::STATUS_OK},
      '{"1ms", 1'b1, 63'd1000000, dtns_pkg::STATUS_OK},
      '{"1s", 1'b1, 63'd1000000000, dtns_pkg::STATUS_OK},
      '{"1m", 1'b1, 63'd60000000000, dtns_pkg::STATUS_OK},
      '{"1h", 1'b1, 63'd3600000000000, dtns_pkg::STATUS_OK},
      '{"1d", 1'b1, 63'd86400000000000, dtns_pkg::STATUS_OK},
      '{"0s", 1'b1, 63'd0, dtns_pkg::STATUS_ZERO},
      '{"ms", 1'b1, 63'd0, dtns_pkg::STATUS_ZERO},
      '{"18446744073709551615ns", 1'b1, 63'd0, dtns_pkg::STATUS_NS_OVF},
      '{"18446744073709551616s", 1'b1, 63'd0, dtns_pkg::STATUS_DIGIT_OVF},
      '{"9223372036854775807ns", 1'b1, 63'd9223372036854775807, dtns_pkg::STATUS_OK},
      '{"9223372036854775808ns", 1'b1, 63'd0, dtns_pkg::STATUS_NS_OVF},
      '{"15", 1'b1, 63'd0, dtns_pkg::STATUS_BAD_UNIT},
      '{"5sec", 1'b1, 63'd0, dtns_pkg::STATUS_BAD_UNIT},
      '{"1s5", 1'b1, 63'd0, dtns_pkg::STATUS_BAD_UNIT},
      '{"2x", 1'b1, 63'd0, dtns_pkg::STATUS_BAD_UNIT},
      '{"99999999999999999999999h", 1'b1, 63'd0, dtns_pkg::STATUS_DIGIT_OVF},
      '{"250ms", 1'b0, 63'd0, dtns_pkg::STATUS_OK},
      '{"106751d", 1'b0, 63'd0, dtns_pkg::STATUS_OK},
      '{"106752d", 1'b0, 63'd0, dtns_pkg::STATUS_OK},
      '{"s1", 1'b0, 63'd0, dtns_pkg::STATUS_OK},
      '{"\377\200", 1'b0, 63'd0, dtns_pkg::STATUS_OK}
   };

   // parser state mirror
   logic               text_fresh;
   logic               in_unit;
   logic [COUNT_W-1:0] count_acc;
   logic               count_ovf;
   logic [CHAR_W-1:0]  unit_c0;
   logic [CHAR_W-1:0]  unit_c1;
   logic [1:0]         unit_len;

   duration_result_type expected_durations [$];
   duration_result_type oldest_duration;
   logic [CHAR_W-1:0] text_bytes [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;
   int chars_sent;
   int texts_sent;
   int results_checked;
   int mismatch_count;

   always #10 clock = ~clock;

   function automatic logic [COUNT_W-1:0] unit_factor();
      if (unit_len == 2'd1) begin
         case (unit_c0)
            dtns_pkg::CHAR_S:  return dtns_pkg::NS_PER_S;
            dtns_pkg::CHAR_M:  return dtns_pkg::NS_PER_MIN;
            dtns_pkg::CHAR_H:  return dtns_pkg::NS_PER_HOUR;
            dtns_pkg::CHAR_D:  return dtns_pkg::NS_PER_DAY;
            default:           return '0;
         endcase
      end
      if (unit_len == 2'd2 && unit_c1 == dtns_pkg::CHAR_S) begin
         case (unit_c0)
            dtns_pkg::CHAR_N:  return dtns_pkg::NS_PER_NS;
            dtns_pkg::CHAR_U:  return dtns_pkg::NS_PER_US;
            dtns_pkg::CHAR_M:  return dtns_pkg::NS_PER_MS;
            default:           return '0;
         endcase
      end
      return '0;
   endfunction

   task automatic clear_parse();
      text_fresh = 1'b1;
      in_unit    = 1'b0;
      count_acc  = '0;
      count_ovf  = 1'b0;
      unit_c0    = '0;
      unit_c1    = '0;
      unit_len   = '0;
   endtask

   task automatic predict_char(input logic [CHAR_W-1:0] c);
      duration_result_type r;
      logic [COUNT_W-1:0] factor;
      logic [COUNT_W-1:0] digit;
      if (c != dtns_pkg::CHAR_NUL) begin
         text_fresh = 1'b0;
         if (!in_unit && c >= dtns_pkg::CHAR_DIG_0 && c <= dtns_pkg::CHAR_DIG_9) begin
            digit = {{(COUNT_W-CHAR_W){1'b0}}, c - dtns_pkg::CHAR_DIG_0};
            if (!count_ovf) begin
               if (count_acc > (COUNT_MAX - digit) / 10)
                  count_ovf = 1'b1;
               else
                  count_acc = count_acc * 10 + digit;
            end
         end else begin
            in_unit = 1'b1;
            if (unit_len == 2'd0)
               unit_c0 = c;
            else if (unit_len == 2'd1)
               unit_c1 = c;
            if (unit_len != 2'd3)
               unit_len = unit_len + 2'd1;
         end
      end else begin
         r.ns = '0;
         factor = unit_factor();
         if (text_fresh)
            r.status = dtns_pkg::STATUS_EMPTY;
         else if (count_ovf)
            r.status = dtns_pkg::STATUS_DIGIT_OVF;
         else if (count_acc == '0)
            r.status = dtns_pkg::STATUS_ZERO;
         else if (factor == '0)
            r.status = dtns_pkg::STATUS_BAD_UNIT;
         else if (count_acc > dtns_pkg::SIGNED_MAX / factor)
            r.status = dtns_pkg::STATUS_NS_OVF;
         else begin
            r.status = dtns_pkg::STATUS_OK;
            r.ns = NS_W'(count_acc * factor);
         end
         expected_durations.push_back(r);
         clear_parse();
      end
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] c);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.char_code = c;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_char(c);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_char(text_bytes[i]);
      send_char(dtns_pkg::CHAR_NUL);
      texts_sent++;
   endtask

   task automatic append_str(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   task automatic append_count(input logic [COUNT_W-1:0] v);
      int zeros;
      zeros = ($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0;
      repeat (zeros) text_bytes.push_back(dtns_pkg::CHAR_DIG_0);
      append_str($sformatf("%0d", v));
   endtask

   task automatic push_digits(input int n);
      repeat (n)
         text_bytes.push_back(CHAR_W'(dtns_pkg::CHAR_DIG_0 + $urandom_range(9, 0)));
   endtask

   task automatic push_junk(input int n);
      string letters;
      letters = "nsumhdx";
      repeat (n) begin
         case ($urandom_range(3, 0))
            0:       text_bytes.push_back(letters[$urandom_range(6, 0)]);
            1:       push_digits(1);
            default: text_bytes.push_back(CHAR_W'($urandom_range(255, 1)));
         endcase
      end
   endtask

   task automatic build_random_text();
      int kind;
      int u;
      logic [COUNT_W-1:0] v;
      text_bytes.delete();
      kind = $urandom_range(99, 0);
      u = $urandom_range(NUM_UNITS - 1, 0);
      if (kind < 52) begin
         push_digits(($urandom_range(9, 0) < 8) ? $urandom_range(6, 1) : $urandom_range(19, 7));
         append_str(unit_names[u]);
      end else if (kind < 67) begin
         v = unit_limits[u] - 64'd1 + COUNT_W'($urandom_range(2, 0));
         append_count(v);
         append_str(unit_names[u]);
      end else if (kind < 73) begin
         v = COUNT_MAX - COUNT_W'($urandom_range(3, 0));
         append_count(v);
         if ($urandom_range(1, 0) == 1) push_digits($urandom_range(3, 1));
         append_str(unit_names[u]);
      end else if (kind < 77) begin
         push_digits($urandom_range(25, 20));
         append_str(unit_names[u]);
      end else if (kind < 81) begin
         repeat ($urandom_range(4, 1)) text_bytes.push_back(dtns_pkg::CHAR_DIG_0);
         append_str(unit_names[u]);
      end else if (kind < 84) begin
         if ($urandom_range(1, 0) == 1) append_str(unit_names[u]);
      end else if (kind < 95) begin
         push_digits($urandom_range(4, 1));
         push_junk($urandom_range(4, 0));
      end else begin
         repeat ($urandom_range(6, 1)) text_bytes.push_back(CHAR_W'($urandom_range(255, 1)));
      end
   endtask

   task automatic run_random(input int budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         build_random_text();
         send_text();
      end
   endtask

   task automatic drain();
      while (expected_durations.size() != 0) @(negedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_durations.size() == 0) begin
            $display("%0t: unexpected result, expected none, got ns=%0d status=%0d",
                     $time, rsp_ch.elapsed_ns, rsp_ch.status);
            mismatch_count++;
         end else begin
            oldest_duration = expected_durations.pop_front();
            results_checked++;
            if (rsp_ch.elapsed_ns !== oldest_duration.ns ||
                rsp_ch.status !== oldest_duration.status) begin
               $display("%0t: result mismatch, expected ns=%0d status=%0d, %s%0d status=%0d",
                        $time, oldest_duration.ns, oldest_duration.status, "got ns=",
                        rsp_ch.elapsed_ns, rsp_ch.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      duration_result_type typed_result;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 72;
      hold_request = 0;
      hold_left = 0;
      chars_sent = 0;
      texts_sent = 0;
      results_checked = 0;
      mismatch_count = 0;
      clear_parse();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_cases[i]) begin
         text_bytes.delete();
         append_str(directed_cases[i].text);
         send_text();
         if (directed_cases[i].known) begin
            typed_result.ns = directed_cases[i].ns;
            typed_result.status = directed_cases[i].status;
            expected_durations[expected_durations.size() - 1] = typed_result;
         end
      end

      run_random(555);
      req_ch.valid = 1'b0;
      drain();

      send_idle_pct = 72;
      recv_idle_pct = 32;
      run_random(555);
      req_ch.valid = 1'b0;
      drain();

      // hold the receiver off while items keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 300;
      run_random(555);
      req_ch.valid = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("Covered %0d texts in %0d bytes under three idle mixes and a long stall.",
               texts_sent, chars_sent);
      $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/dtns_pkg.sv
rtl/dtns_req_if.sv
rtl/dtns_rsp_if.sv
rtl/dtns_parser.sv
rtl/dtns_scaler.sv
rtl/duration_text_to_nanoseconds.sv
test/tb_top.sv
